FILE: hdl/bigram_frequency_table_unit_assert.svh
// assertion macros for the bigram frequency table
`ifndef BIGRAM_FREQUENCY_TABLE_UNIT_ASSERT_SVH
`define BIGRAM_FREQUENCY_TABLE_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bft check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define BFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bft check failed");

`endif

FILE: hdl/bft_pkg.sv
// package: types, codes and constants of the bigram frequency table
package bft_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam logic [30:0] FREQ_MAX = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_SORT   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_IDX  = 2'd2,
    ST_RESERVED = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [30:0] frequency;
    logic [7:0]  index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [7:0]  out_first;
    logic [7:0]  out_second;
    logic [30:0] out_freq;
    logic [8:0]  entries_used;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_APP_WR,
    S_RD_WAIT,
    S_RD_DONE,
    S_SO_RDI,
    S_SO_WAITI,
    S_SO_RDJ,
    S_SO_CMP,
    S_SO_INS,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the input word
    logic scan_clr;    // scan pointer to zero
    logic scan_rd;     // read entry at scan pointer
    logic scan_step;   // advance scan pointer, note a match
    logic app_write;   // write update or new entry
    logic idx_rd;      // read entry at requested index
    logic so_init;     // sort: i to one
    logic so_rd_i;     // sort: read entry i into hold
    logic so_take_i;   // sort: latch hold, j = i
    logic so_rd_j;     // sort: read entry j-1
    logic so_shift;    // sort: move j-1 to j, j--
    logic so_ins;      // sort: write hold at j, i++
    logic do_clear;    // fill to zero
    logic res_load;    // build result word
    logic res_give;    // present result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;   // scan pointer has reached fill
    logic idx_bad;     // requested index not below fill
    logic so_done;     // i has reached fill
    logic j_zero;      // j at zero
    logic moves;       // hold goes before entry j-1
    logic out_busy;    // result register holds an untaken word
  } sts_t;

endpackage

FILE: hdl/bigram_frequency_table_unit.sv
// top level of the bigram frequency table
//   channel  signals                         direction
//   in       in_valid, in_ready, in_data     command word in
//   out      out_valid, out_ready, out_data  result word out
// An append scans every filled slot.
// A sort is an insertion sort over one memory port.
// One command is worked at a time; a new one is taken once the result is handed on.
// rst_n is synchronous and empties the table; entry contents are not cleared.
module bigram_frequency_table_unit #(
  parameter int unsigned CAPACITY = bft_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bft_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bft_pkg::out_word_t out_data
);

  bft_pkg::ctl_t ctl;
  bft_pkg::sts_t sts;

  bft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (bft_pkg::cmd_t'(in_data.cmd)),
    .sts      (sts),
    .ctl      (ctl)
  );

  bft_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_data)
  );

endmodule

FILE: hdl/bft_ctrl.sv
// controller state machine of the bigram frequency table
module bft_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bft_pkg::cmd_t cmd,
  input  bft_pkg::sts_t sts,
  output bft_pkg::ctl_t ctl
);

  bft_pkg::state_t state_r, state_nxt;
  logic            take;

  // a word is taken only once the result register is free
  assign take = in_valid && !sts.out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bft_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bft_pkg::S_IDLE: begin
        if (take) begin
          unique case (cmd)
            bft_pkg::CMD_APPEND: state_nxt = bft_pkg::S_SRCH_RD;
            bft_pkg::CMD_SORT:   state_nxt = bft_pkg::S_SO_RDI;
            bft_pkg::CMD_READ:   state_nxt = bft_pkg::S_RD_WAIT;
            default:             state_nxt = bft_pkg::S_RESULT;
          endcase
        end
      end
      bft_pkg::S_SRCH_RD: begin
        state_nxt = sts.scan_last ? bft_pkg::S_APP_WR : bft_pkg::S_SRCH_CMP;
      end
      bft_pkg::S_SRCH_CMP: state_nxt = bft_pkg::S_SRCH_RD;
      bft_pkg::S_APP_WR:   state_nxt = bft_pkg::S_RESULT;
      bft_pkg::S_RD_WAIT:  state_nxt = bft_pkg::S_RD_DONE;
      bft_pkg::S_RD_DONE:  state_nxt = bft_pkg::S_RESULT;
      bft_pkg::S_SO_RDI: begin
        state_nxt = sts.so_done ? bft_pkg::S_RESULT : bft_pkg::S_SO_WAITI;
      end
      bft_pkg::S_SO_WAITI: state_nxt = bft_pkg::S_SO_RDJ;
      bft_pkg::S_SO_RDJ: begin
        state_nxt = sts.j_zero ? bft_pkg::S_SO_INS : bft_pkg::S_SO_CMP;
      end
      bft_pkg::S_SO_CMP: begin
        state_nxt = sts.moves ? bft_pkg::S_SO_RDJ : bft_pkg::S_SO_INS;
      end
      bft_pkg::S_SO_INS: state_nxt = bft_pkg::S_SO_RDI;
      bft_pkg::S_RESULT: begin
        if (!sts.out_busy) begin
          state_nxt = bft_pkg::S_IDLE;
        end
      end
      default: state_nxt = bft_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    unique case (state_r)
      bft_pkg::S_IDLE: begin
        in_ready = !sts.out_busy;
        if (take) begin
          ctl.capture  = 1'b1;
          ctl.scan_clr = (cmd == bft_pkg::CMD_APPEND);
          ctl.so_init  = (cmd == bft_pkg::CMD_SORT);
          if (cmd == bft_pkg::CMD_CLEAR) begin
            ctl.do_clear = 1'b1;
          end
        end
      end
      bft_pkg::S_SRCH_RD: begin
        if (!sts.scan_last) begin
          ctl.scan_rd = 1'b1;
        end
      end
      bft_pkg::S_SRCH_CMP: ctl.scan_step = 1'b1;
      bft_pkg::S_APP_WR:   ctl.app_write = 1'b1;
      bft_pkg::S_RD_WAIT:  ctl.idx_rd = 1'b1;
      bft_pkg::S_RD_DONE:  ;
      bft_pkg::S_SO_RDI: begin
        if (!sts.so_done) begin
          ctl.so_rd_i = 1'b1;
        end
      end
      bft_pkg::S_SO_WAITI: ctl.so_take_i = 1'b1;
      bft_pkg::S_SO_RDJ: begin
        if (!sts.j_zero) begin
          ctl.so_rd_j = 1'b1;
        end
      end
      bft_pkg::S_SO_CMP: begin
        if (sts.moves) begin
          ctl.so_shift = 1'b1;
        end
      end
      bft_pkg::S_SO_INS: ctl.so_ins = 1'b1;
      bft_pkg::S_RESULT: begin
        if (!sts.out_busy) begin
          ctl.res_give = 1'b1;
        end
      end
      default: ;
    endcase
    // result fields are built in the cycle before they are presented
    ctl.res_load = (state_r == bft_pkg::S_APP_WR) || (state_r == bft_pkg::S_RD_DONE) ||
                   (state_r == bft_pkg::S_SO_RDI && sts.so_done) ||
                   (state_r == bft_pkg::S_IDLE && take && cmd == bft_pkg::CMD_CLEAR);
  end

endmodule

FILE: hdl/bft_dp.sv
// datapath of the bigram frequency table: entry memory, scan, sort and result
`include "bigram_frequency_table_unit_assert.svh"

module bft_dp #(
  parameter int unsigned CAPACITY = bft_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bft_pkg::in_word_t  in_word,
  input  bft_pkg::ctl_t      ctl,
  output bft_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_ready,
  output bft_pkg::out_word_t out_word
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // entry word: first, second, count
  localparam int unsigned EW = 47;

  logic [EW-1:0] mem [CAPACITY];

  bft_pkg::in_word_t cur_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] ptr_r;       // scan pointer, also sort index i
  logic [CW-1:0] j_r;
  logic [AW-1:0] pos_r;
  logic          found_r;
  logic [EW-1:0] rd_r;
  logic [EW-1:0] hold_r;
  logic          out_valid_r;
  bft_pkg::out_word_t out_r;
  bft_pkg::out_word_t out_nxt;

  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;
  logic          key_hit;
  logic [30:0]   hit_cnt_r;
  logic [31:0]   hsum;
  logic [30:0]   upd_cnt;

  assign key_hit = (rd_r[46:39] == cur_r.first_char) && (rd_r[38:31] == cur_r.second_char);

  // memory address selection
  always_comb begin
    rd_en   = ctl.scan_rd || ctl.idx_rd || ctl.so_rd_i || ctl.so_rd_j;
    rd_addr = ptr_r[AW-1:0];
    if (ctl.idx_rd) begin
      rd_addr = AW'(cur_r.index);
    end else if (ctl.so_rd_j) begin
      rd_addr = AW'(j_r - CW'(1));
    end
    wr_en   = 1'b0;
    wr_addr = j_r[AW-1:0];
    wr_data = hold_r;
    if (ctl.app_write && found_r) begin
      wr_en   = 1'b1;
      wr_addr = pos_r;
      wr_data = {cur_r.first_char, cur_r.second_char, upd_cnt};
    end else if (ctl.app_write && (fill_r != CW'(CAPACITY))) begin
      wr_en   = 1'b1;
      wr_addr = fill_r[AW-1:0];
      wr_data = {cur_r.first_char, cur_r.second_char, cur_r.frequency};
    end else if (ctl.so_shift) begin
      wr_en   = 1'b1;
      wr_addr = j_r[AW-1:0];
      wr_data = rd_r;
    end else if (ctl.so_ins) begin
      wr_en   = 1'b1;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // input word and sort hold register
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cur_r <= in_word;
    end
    if (ctl.so_take_i) begin
      hold_r <= rd_r;
    end
  end

  // search and sort pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      j_r     <= '0;
      pos_r   <= '0;
      found_r <= 1'b0;
    end else begin
      if (ctl.scan_clr) begin
        ptr_r <= '0;
      end else if (ctl.so_init) begin
        ptr_r <= CW'(1);
      end else if (ctl.scan_step || ctl.so_ins) begin
        ptr_r <= ptr_r + CW'(1);
      end
      if (ctl.scan_clr) begin
        found_r <= 1'b0;
      end else if (ctl.scan_step && key_hit) begin
        found_r <= 1'b1;
        pos_r   <= AW'(ptr_r);
      end
      if (ctl.so_take_i) begin
        j_r <= ptr_r;
      end else if (ctl.so_shift) begin
        j_r <= j_r - CW'(1);
      end
    end
  end

  // append update needs the old count of the matched entry: it is the last
  // hit of the scan, so its count is kept when the hit is seen
  always_ff @(posedge clk) begin
    if (ctl.scan_step && key_hit) begin
      hit_cnt_r <= rd_r[30:0];
    end
  end
  assign hsum    = {1'b0, hit_cnt_r} + {1'b0, cur_r.frequency};
  assign upd_cnt = hsum[31] ? bft_pkg::FREQ_MAX : hsum[30:0];

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctl.do_clear) begin
      fill_r <= '0;
    end else if (ctl.app_write && !found_r && (fill_r != CW'(CAPACITY))) begin
      fill_r <= fill_r + CW'(1);
    end
  end

  // result word
  always_comb begin
    out_nxt = '0;
    out_nxt.status = bft_pkg::ST_OK;
    out_nxt.entries_used = 9'(fill_r);
    if (ctl.do_clear) begin
      out_nxt.entries_used = '0;
    end else if (ctl.app_write) begin
      if (found_r) begin
        out_nxt.slot       = 8'(pos_r);
        out_nxt.out_first  = cur_r.first_char;
        out_nxt.out_second = cur_r.second_char;
        out_nxt.out_freq   = upd_cnt;
      end else if (fill_r == CW'(CAPACITY)) begin
        out_nxt.status = bft_pkg::ST_FULL;
      end else begin
        out_nxt.slot         = 8'(fill_r);
        out_nxt.out_first    = cur_r.first_char;
        out_nxt.out_second   = cur_r.second_char;
        out_nxt.out_freq     = cur_r.frequency;
        out_nxt.entries_used = 9'(fill_r + CW'(1));
      end
    end else if (cur_r.cmd == bft_pkg::CMD_READ) begin
      out_nxt.slot = cur_r.index;
      if (sts.idx_bad) begin
        out_nxt.status = bft_pkg::ST_BAD_IDX;
      end else begin
        out_nxt.out_first  = rd_r[46:39];
        out_nxt.out_second = rd_r[38:31];
        out_nxt.out_freq   = rd_r[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.res_give) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // status to the controller
  always_comb begin
    sts.scan_last = (ptr_r == fill_r);
    sts.idx_bad   = (32'(cur_r.index) >= 32'(fill_r));
    sts.so_done   = (ptr_r >= fill_r);
    sts.j_zero    = (j_r == '0);
    // hold goes before entry j-1: higher count, or equal count and smaller key
    sts.moves     = (hold_r[30:0] > rd_r[30:0]) ||
                    ((hold_r[30:0] == rd_r[30:0]) && (hold_r[46:31] < rd_r[46:31]));
    sts.out_busy  = out_valid_r && !out_ready;
  end

  `BFT_ASSERT_IMPL(a_fill_cap, clk, rst_n, 1'b1, fill_r <= CW'(CAPACITY))
  `BFT_ASSERT_NEXT(a_clear_empty, clk, rst_n, ctl.do_clear, fill_r == '0)
  `BFT_ASSERT_IMPL(a_one_write, clk, rst_n, ctl.so_shift, !ctl.so_ins && !ctl.app_write)
  `BFT_ASSERT_IMPL(a_shift_j, clk, rst_n, ctl.so_shift, j_r != '0)

endmodule
